@@ hdl/length_prefixed_message_ring_defines.svh @@
// Assertion macros for the length-prefixed message ring.
`ifndef LENGTH_PREFIXED_MESSAGE_RING_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LPMR_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define LPMR_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/lpmr_pkg.sv @@
// Types and codes shared by the length-prefixed message ring.
`timescale 1ns / 1ps
`default_nettype none
package lpmr_pkg;

  localparam int unsigned MAX_MESSAGE = 60;
  localparam int unsigned HDR_BYTES   = 4;

  localparam logic [2:0] KIND_PUSH_BEGIN = 3'd0;
  localparam logic [2:0] KIND_PUSH_DATA  = 3'd1;
  localparam logic [2:0] KIND_POP        = 3'd2;
  localparam logic [2:0] KIND_PEEK       = 3'd3;
  localparam logic [2:0] KIND_DISCARD    = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_CORRUPT   = 3'd4;
  localparam logic [2:0] ST_OUT_SMALL = 3'd5;
  localparam logic [2:0] ST_SEQ_ERR   = 3'd6;

  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_RESERVE  = 2'd1;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] msg_length;
    logic [7:0] data_byte;
    logic [5:0] out_limit;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_byte;
    logic [5:0]  msg_length_out;
    logic        last;
    logic [12:0] used_bytes;
    logic [12:0] free_bytes;
  } rsp_t;

endpackage
`default_nettype wire

@@ hdl/lpmr_ram.sv @@
// Byte store of the ring: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module lpmr_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/length_prefixed_message_ring.sv @@
// Top level of the length-prefixed message ring: sequencer, pointers and counts.
`timescale 1ns / 1ps
`default_nettype none
// A byte ring holds messages of 1 to 60 bytes, each behind a 4-byte
// little-endian length header. Issue a request with start while busy is low;
// results appear on result for one cycle each, marked by result_valid, and
// cannot be stalled, so the receiver must take every strobe. All ring bytes
// live in one single-port-write, single-port-read memory, which sets the
// timing. push_data and any error found at the request pass through the emit
// state and give one result; push_begin writes the header one byte a cycle
// and then emits; discard, and any pop or peek that fails the header check,
// reads the header one byte a cycle, checks it and emits; pop and peek read
// and check the header, then stream one byte per cycle with last on the final
// byte. Configuration writes are taken while busy and start are both low;
// a capacity write empties the ring. No clearing pass runs after reset.
`include "length_prefixed_message_ring_defines.svh"
module length_prefixed_message_ring #(
  parameter int CAPACITY = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire lpmr_pkg::req_t  request,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [12:0]     cfg_data,
  output logic                 result_valid,
  output lpmr_pkg::rsp_t       result
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW + 1 > 10) ? CW + 1 : 10;
  localparam int WW = (CW > 13) ? CW : 13;
  localparam int CAP_RESET = (CAPACITY < 4096) ? CAPACITY : 4096;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HDRW   = 3'd1;
  localparam logic [2:0] S_HRD    = 3'd2;
  localparam logic [2:0] S_HCHK   = 3'd3;
  localparam logic [2:0] S_STREAM = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]    state;
  logic [CW-1:0] cap;
  logic [7:0]    reserve;
  logic [PW-1:0] head, tail, wm;
  logic          wmv;
  logic [5:0]    rem;
  logic [CW-1:0] pp;
  logic [2:0]    cnt;
  logic [5:0]    si;
  logic          pend;
  logic          pend_last;

  // Request and header payload
  logic [2:0]    kind_q;
  logic [5:0]    len_q;
  logic [5:0]    lim_q;
  logic [2:0]    st_q;
  logic [5:0]    lo_q;
  logic [PW-1:0] start_q;
  logic          jump_q;
  logic [7:0]    hb [4];

  // Memory ports
  logic          we;
  logic [PW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  // Occupancy
  logic [CW-1:0] used, rf, freec;
  logic [XW-1:0] usedx, rfx, capx, resx;

  // Push-begin and head checks
  logic [XW-1:0] needx, resneed;
  logic          pb_short;
  logic [2:0]    pb_st;
  logic [PW-1:0] pb_tail;
  logic          hd_jump;
  logic [PW-1:0] hd_start;
  logic [2:0]    hd_st;
  logic [2:0]    idle_st;
  logic [5:0]    hlen;
  logic [XW-1:0] nh;
  logic [2:0]    hc_st;

  lpmr_ram #(.DEPTH(CAPACITY), .AW(PW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy      = (state != S_IDLE);
  // Hold off register writes while a request is being taken.
  assign cfg_ready = (state == S_IDLE) && !start;

  // Used and free counts straight from the pointers.
  always_comb begin
    rf   = cap;
    used = '0;
    if (head == tail) begin
      rf   = cap;
      used = '0;
    end else if (head < tail) begin
      used = CW'(tail) - CW'(head);
      rf   = cap - used;
    end else begin
      rf = CW'(head) - CW'(tail);
      if (wmv) begin
        used = (wm >= head) ? CW'(wm) - CW'(head) + CW'(tail) : CW'(tail);
      end else begin
        used = cap - CW'(head) + CW'(tail);
      end
    end
    usedx = XW'(used);
    rfx   = XW'(rf);
    capx  = XW'(cap);
    resx  = XW'(reserve);
    freec = (rfx < resx) ? '0 : CW'(rfx - resx);
  end

  // Push-begin: sequence, length and space checks, then the short tail gap that forces a wrap.
  always_comb begin
    needx    = XW'(request.msg_length) + XW'(lpmr_pkg::HDR_BYTES);
    resneed  = resx + needx;
    pb_short = (capx - XW'(tail)) < needx;
    pb_tail  = pb_short ? '0 : tail;
    pb_st    = lpmr_pkg::ST_OK;
    if (rem != 6'd0) begin
      pb_st = lpmr_pkg::ST_SEQ_ERR;
    end else if (request.msg_length == 6'd0 ||
                 request.msg_length > 6'(lpmr_pkg::MAX_MESSAGE)) begin
      pb_st = lpmr_pkg::ST_BAD_LEN;
    end else if (rfx < resneed || rfx <= needx) begin
      pb_st = lpmr_pkg::ST_FULL;
    end else if (pb_short) begin
      if (wmv || head > tail) begin
        pb_st = lpmr_pkg::ST_CORRUPT;
      end else if (XW'(head) < resneed || XW'(head) <= needx) begin
        pb_st = lpmr_pkg::ST_FULL;
      end
    end
  end

  // Head access: empty and short checks, and the jump past the wrap mark.
  always_comb begin
    hd_jump  = wmv && (head == wm);
    hd_start = hd_jump ? '0 : head;
    hd_st    = lpmr_pkg::ST_OK;
    if (used == '0) begin
      hd_st = lpmr_pkg::ST_EMPTY;
    end else if (usedx <= XW'(lpmr_pkg::HDR_BYTES)) begin
      hd_st = lpmr_pkg::ST_CORRUPT;
    end else if (XW'(hd_start) + XW'(lpmr_pkg::HDR_BYTES) > capx) begin
      hd_st = lpmr_pkg::ST_CORRUPT;
    end
  end

  always_comb begin
    case (request.kind)
      lpmr_pkg::KIND_PUSH_BEGIN: idle_st = pb_st;
      lpmr_pkg::KIND_PUSH_DATA:  idle_st = (rem == 6'd0) ? lpmr_pkg::ST_SEQ_ERR
                                                        : lpmr_pkg::ST_OK;
      lpmr_pkg::KIND_POP,
      lpmr_pkg::KIND_PEEK,
      lpmr_pkg::KIND_DISCARD:    idle_st = hd_st;
      default:                   idle_st = lpmr_pkg::ST_SEQ_ERR;
    endcase
  end

  // Header check once all four bytes are in.
  always_comb begin
    hlen  = hb[0][5:0];
    nh    = XW'(start_q) + XW'(lpmr_pkg::HDR_BYTES) + XW'(hb[0]);
    hc_st = lpmr_pkg::ST_OK;
    if (hb[1] != 8'd0 || hb[2] != 8'd0 || hb[3] != 8'd0 || hb[0] == 8'd0 ||
        hb[0] > 8'(lpmr_pkg::MAX_MESSAGE) ||
        XW'(hb[0]) > usedx - XW'(lpmr_pkg::HDR_BYTES) || nh > capx) begin
      hc_st = lpmr_pkg::ST_CORRUPT;
    end else if (kind_q == lpmr_pkg::KIND_POP && hlen > lim_q) begin
      hc_st = lpmr_pkg::ST_OUT_SMALL;
    end
  end

  // Memory port selection: push_data writes in the accept cycle, headers
  // go out one byte per cycle.
  always_comb begin
    we    = 1'b0;
    waddr = pp[PW-1:0];
    wdata = request.data_byte;
    if (state == S_IDLE && start && request.kind == lpmr_pkg::KIND_PUSH_DATA &&
        rem != 6'd0) begin
      we = 1'b1;
    end else if (state == S_HDRW) begin
      we    = 1'b1;
      waddr = PW'(XW'(tail) + XW'(cnt));
      wdata = (cnt == 3'd0) ? 8'(len_q) : 8'd0;
    end
    if (state == S_STREAM) begin
      raddr = PW'(XW'(start_q) + XW'(lpmr_pkg::HDR_BYTES) + XW'(si));
    end else begin
      raddr = PW'(XW'(start_q) + XW'(cnt[1:0]));
    end
  end

  // Sequencer and ring pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cap          <= CW'(CAP_RESET);
      reserve      <= 8'd8;
      head         <= '0;
      tail         <= '0;
      wm           <= '0;
      wmv          <= 1'b0;
      rem          <= '0;
      pp           <= '0;
      cnt          <= '0;
      si           <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      pend         <= 1'b0;
      result_valid <= (state == S_EMIT) || pend;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EMIT;
            case (request.kind)
              lpmr_pkg::KIND_PUSH_BEGIN: begin
                if (pb_st == lpmr_pkg::ST_OK) begin
                  // Record the wrap mark and restart the tail at zero.
                  if (pb_short) begin
                    wm   <= tail;
                    wmv  <= 1'b1;
                    tail <= '0;
                  end
                  pp    <= CW'(pb_tail) + CW'(lpmr_pkg::HDR_BYTES);
                  rem   <= request.msg_length;
                  cnt   <= '0;
                  state <= S_HDRW;
                end
              end
              lpmr_pkg::KIND_PUSH_DATA: begin
                if (rem != 6'd0) begin
                  pp  <= pp + CW'(1);
                  rem <= rem - 6'd1;
                  // Commit the tail with the final byte.
                  if (rem == 6'd1) begin
                    tail <= (pp + CW'(1) >= cap) ? '0 : PW'(pp + CW'(1));
                  end
                end
              end
              lpmr_pkg::KIND_POP,
              lpmr_pkg::KIND_PEEK,
              lpmr_pkg::KIND_DISCARD: begin
                if (hd_st == lpmr_pkg::ST_OK) begin
                  cnt   <= '0;
                  state <= S_HRD;
                end
              end
              default: begin
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_HDRW: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd3) begin
            state <= S_EMIT;
          end
        end
        S_HRD: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) begin
            state <= S_HCHK;
          end
        end
        S_HCHK: begin
          if (hc_st != lpmr_pkg::ST_OK) begin
            state <= S_EMIT;
          end else begin
            // Pop and discard advance the head past the message.
            if (kind_q != lpmr_pkg::KIND_PEEK) begin
              if (jump_q) begin
                wmv <= 1'b0;
              end
              head <= (nh >= capx) ? '0 : PW'(nh);
            end
            if (kind_q == lpmr_pkg::KIND_DISCARD) begin
              state <= S_EMIT;
            end else begin
              si    <= '0;
              state <= S_STREAM;
            end
          end
        end
        S_STREAM: begin
          pend <= 1'b1;
          if (si == len_q - 6'd1) begin
            state <= S_DRAIN;
          end else begin
            si <= si + 6'd1;
          end
        end
        S_DRAIN: begin
          state <= S_IDLE;
        end
        S_EMIT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lpmr_pkg::CFG_CAPACITY: begin
            // Saturate the capacity and empty the ring.
            if (WW'(cfg_data) < WW'(64)) begin
              cap <= CW'(64);
            end else if (WW'(cfg_data) > WW'(CAPACITY)) begin
              cap <= CW'(CAPACITY);
            end else begin
              cap <= CW'(cfg_data);
            end
            head <= '0;
            tail <= '0;
            wm   <= '0;
            wmv  <= 1'b0;
            rem  <= '0;
            pp   <= '0;
          end
          lpmr_pkg::CFG_RESERVE: begin
            reserve <= cfg_data[7:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Request payload, header bytes and result fields.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      kind_q  <= request.kind;
      len_q   <= request.msg_length;
      lim_q   <= request.out_limit;
      st_q    <= idle_st;
      lo_q    <= '0;
      start_q <= hd_start;
      jump_q  <= hd_jump;
    end
    if (state == S_HRD && cnt != 3'd0) begin
      hb[2'(cnt - 3'd1)] <= rdata;
    end
    if (state == S_HCHK) begin
      st_q  <= hc_st;
      len_q <= hlen;
      lo_q  <= (hc_st == lpmr_pkg::ST_CORRUPT) ? 6'd0 : hlen;
    end
    pend_last <= (si == len_q - 6'd1);
    if (state == S_EMIT) begin
      result.status         <= st_q;
      result.out_byte       <= 8'd0;
      result.msg_length_out <= lo_q;
      result.last           <= 1'b1;
      result.used_bytes     <= 13'(used);
      result.free_bytes     <= 13'(freec);
    end else if (pend) begin
      result.status         <= lpmr_pkg::ST_OK;
      result.out_byte       <= rdata;
      result.msg_length_out <= lo_q;
      result.last           <= pend_last;
      result.used_bytes     <= 13'(used);
      result.free_bytes     <= 13'(freec);
    end
  end

  `LPMR_ASSERT_IMP(a_ptr_in_ring, clk, rst, 1'b1, (CW'(head) < cap) && (CW'(tail) < cap), "ring pointer at or beyond capacity")
  `LPMR_ASSERT_NXT(a_stream_gapless, clk, rst, result_valid && !result.last, result_valid, "gap inside a streamed message")
  `LPMR_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "request taken without going busy")

endmodule
`default_nettype wire

@@ test/lpmr_ring_checker.sv @@
// Checker for the message ring: tracks ring state, predicts results and compares them.
`timescale 1ns / 1ps
module lpmr_ring_checker
  import lpmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  req_t        request,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        result_valid,
  input  rsp_t        result,
  output int          fail_count,
  output int          pending
);

  localparam int unsigned RING_MAX = 4096;

  logic [7:0]  ring_mem [RING_MAX];
  int unsigned head_ptr, tail_ptr, wrap_at, fill_ptr, fill_left;
  bit          wrap_set;
  int unsigned cap_reg, reserve_reg;
  rsp_t        expected_q[$];
  int          mismatches;

  assign fail_count = mismatches;
  assign pending    = expected_q.size();

  function automatic int unsigned ring_size();
    if (cap_reg < 64) return 64;
    if (cap_reg > RING_MAX) return RING_MAX;
    return cap_reg;
  endfunction

  function automatic int unsigned gap_bytes();
    if (head_ptr == tail_ptr) return ring_size();
    if (head_ptr < tail_ptr) return ring_size() - (tail_ptr - head_ptr);
    return head_ptr - tail_ptr;
  endfunction

  function automatic int unsigned spare_bytes();
    return (gap_bytes() < reserve_reg) ? 0 : gap_bytes() - reserve_reg;
  endfunction

  function automatic int unsigned held_bytes();
    if (head_ptr == tail_ptr) return 0;
    if (head_ptr < tail_ptr) return tail_ptr - head_ptr;
    if (wrap_set) return (wrap_at >= head_ptr) ? wrap_at - head_ptr + tail_ptr : tail_ptr;
    return ring_size() - head_ptr + tail_ptr;
  endfunction

  function automatic logic [7:0] ring_byte(int unsigned i);
    return (i < RING_MAX) ? ring_mem[i] : 8'h00;
  endfunction

  // Queue one expected result; counts reflect the state at this point.
  function automatic void expect_rsp(logic [2:0] st, logic [7:0] b, int unsigned len, bit fin);
    rsp_t r;
    r.status         = st;
    r.out_byte       = b;
    r.msg_length_out = len[5:0];
    r.last           = fin;
    r.used_bytes     = 13'(held_bytes());
    r.free_bytes     = 13'(spare_bytes());
    expected_q.push_back(r);
  endfunction

  function automatic void clear_ring();
    head_ptr  = 0;
    tail_ptr  = 0;
    wrap_at   = 0;
    wrap_set  = 0;
    fill_left = 0;
    fill_ptr  = 0;
  endfunction

  function automatic void predict_push_begin(int unsigned len);
    int unsigned need;
    need = len + HDR_BYTES;
    if (fill_left != 0) begin
      expect_rsp(ST_SEQ_ERR, 0, 0, 1);
    end else if (len == 0 || len > MAX_MESSAGE) begin
      expect_rsp(ST_BAD_LEN, 0, 0, 1);
    end else if (gap_bytes() < reserve_reg + need || gap_bytes() <= need) begin
      expect_rsp(ST_FULL, 0, 0, 1);
    end else if (ring_size() - tail_ptr < need && (wrap_set || head_ptr > tail_ptr)) begin
      expect_rsp(ST_CORRUPT, 0, 0, 1);
    end else if (ring_size() - tail_ptr < need &&
                 (head_ptr < reserve_reg + need || head_ptr <= need)) begin
      expect_rsp(ST_FULL, 0, 0, 1);
    end else begin
      // Short gap at the ring end: mark it and restart the message at 0.
      if (ring_size() - tail_ptr < need) begin
        wrap_at  = tail_ptr;
        wrap_set = 1;
        tail_ptr = 0;
      end
      for (int i = 0; i < HDR_BYTES; i++)
        ring_mem[tail_ptr + i] = (i == 0) ? len[7:0] : 8'h00;
      fill_ptr  = tail_ptr + HDR_BYTES;
      fill_left = len;
      expect_rsp(ST_OK, 0, 0, 1);
    end
  endfunction

  function automatic void predict_push_data(logic [7:0] b);
    if (fill_left == 0) begin
      expect_rsp(ST_SEQ_ERR, 0, 0, 1);
    end else begin
      if (fill_ptr < RING_MAX) ring_mem[fill_ptr] = b;
      fill_ptr++;
      fill_left--;
      // Commit the tail with the final byte.
      if (fill_left == 0) tail_ptr = (fill_ptr >= ring_size()) ? 0 : fill_ptr;
      expect_rsp(ST_OK, 0, 0, 1);
    end
  endfunction

  function automatic void predict_head(logic [2:0] kind, int unsigned lim);
    int unsigned used, base, len, nxt;
    bit          jump;
    used = held_bytes();
    base = head_ptr;
    jump = 0;
    if (wrap_set && head_ptr == wrap_at) begin
      base = 0;
      jump = 1;
    end
    len = 0;
    for (int i = 0; i < HDR_BYTES; i++) len |= int'(ring_byte(base + i)) << (8 * i);
    if (used == 0) begin
      expect_rsp(ST_EMPTY, 0, 0, 1);
    end else if (used <= HDR_BYTES || base + HDR_BYTES > ring_size() || len == 0 ||
                 len > MAX_MESSAGE || len > used - HDR_BYTES ||
                 base + HDR_BYTES + len > ring_size()) begin
      expect_rsp(ST_CORRUPT, 0, 0, 1);
    end else if (kind == KIND_POP && len > lim) begin
      expect_rsp(ST_OUT_SMALL, 0, len, 1);
    end else begin
      // Pop and discard advance the head, hopping past the wrap mark.
      if (kind != KIND_PEEK) begin
        if (jump) wrap_set = 0;
        nxt = base + HDR_BYTES + len;
        head_ptr = (nxt >= ring_size()) ? 0 : nxt;
      end
      if (kind == KIND_DISCARD) begin
        expect_rsp(ST_OK, 0, len, 1);
      end else begin
        for (int unsigned i = 0; i < len; i++)
          expect_rsp(ST_OK, ring_byte(base + HDR_BYTES + i), len, (i + 1 == len));
      end
    end
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      cap_reg     = RING_MAX;
      reserve_reg = 8;
      clear_ring();
      expected_q.delete();
      mismatches  <= 0;
    end else begin
      // Compare first, so a result never meets an expectation queued this edge.
      if (result_valid) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding: %p", result);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_q.pop_front();
          if (result !== want) begin
            mismatches <= mismatches + 1;
            if (result.status !== want.status)
              $error("status: expected %0d, got %0d", want.status, result.status);
            if (result.out_byte !== want.out_byte)
              $error("out_byte: expected %0d, got %0d", want.out_byte, result.out_byte);
            if (result.msg_length_out !== want.msg_length_out)
              $error("msg_length_out: expected %0d, got %0d",
                     want.msg_length_out, result.msg_length_out);
            if (result.last !== want.last)
              $error("last: expected %0d, got %0d", want.last, result.last);
            if (result.used_bytes !== want.used_bytes)
              $error("used_bytes: expected %0d, got %0d", want.used_bytes, result.used_bytes);
            if (result.free_bytes !== want.free_bytes)
              $error("free_bytes: expected %0d, got %0d", want.free_bytes, result.free_bytes);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CAPACITY) begin
          cap_reg = cfg_data;
          clear_ring();
        end else if (cfg_index == CFG_RESERVE) begin
          reserve_reg = cfg_data[7:0];
        end
      end
      if (start && !busy) begin
        case (request.kind)
          KIND_PUSH_BEGIN: predict_push_begin(request.msg_length);
          KIND_PUSH_DATA:  predict_push_data(request.data_byte);
          KIND_POP, KIND_PEEK, KIND_DISCARD: predict_head(request.kind, request.out_limit);
          default:         expect_rsp(ST_SEQ_ERR, 0, 0, 1);
        endcase
      end
    end
  end

endmodule

@@ test/tb_length_prefixed_message_ring.sv @@
// Testbench top for the message ring: drives requests and register writes, gives the verdict.
`timescale 1ns / 1ps
module tb_length_prefixed_message_ring;
  import lpmr_pkg::*;

  // Bound on the whole run: many times the worst case per request plus gaps.
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        request;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        result_valid;
  rsp_t        result;
  int          fail_count;
  int          pending;
  int          cycles;
  int          sent;
  int          burst_left;

  length_prefixed_message_ring dut (
    .clk, .rst, .start, .busy, .request, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .result_valid, .result
  );

  lpmr_ring_checker checker_i (
    .clk, .rst, .start, .busy, .request, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .result_valid, .result, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops results.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Hold one request on the port until the block takes it, then either keep start
  // high for the next request in the burst or drop it for a random gap.
  task automatic send(logic [2:0] kind, logic [5:0] len, logic [7:0] b, logic [5:0] lim);
    start   <= 1'b1;
    request <= '{kind: kind, msg_length: len, data_byte: b, out_limit: lim};
    do @(posedge clk); while (busy);
    sent++;
    if (burst_left == 0) begin
      start <= 1'b0;
      burst_left = $urandom_range(0, 12);
      // Now and then drain every outstanding result before going on.
      if ($urandom_range(0, 30) == 0)
        while (pending != 0) @(posedge clk);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Stop sending and let the block fall fully idle.
  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Push one well-formed message with random content.
  task automatic push_message(int len);
    send(KIND_PUSH_BEGIN, len, $urandom, $urandom);
    for (int i = 0; i < len; i++) begin
      // Peek at the head mid-push now and then.
      if ($urandom_range(0, 40) == 0) send(KIND_PEEK, $urandom, $urandom, $urandom);
      send(KIND_PUSH_DATA, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic random_phase(int count);
    int stop_at, pick, len;
    stop_at = sent + count;
    while (sent < stop_at) begin
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 16) : $urandom_range(1, 60);
      if (pick < 45) begin
        push_message(len);
      end else if (pick < 70) begin
        send(KIND_POP, $urandom, $urandom,
             ($urandom_range(0, 3) != 0) ? 6'd63 : 6'($urandom_range(0, 63)));
      end else if (pick < 80) begin
        send(KIND_PEEK, $urandom, $urandom, $urandom);
      end else if (pick < 88) begin
        send(KIND_DISCARD, $urandom, $urandom, $urandom);
      end else if (pick < 92) begin
        send(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom);
      end else if (pick < 95) begin
        send(KIND_PUSH_BEGIN, ($urandom_range(0, 1) != 0) ? 6'd0 : 6'($urandom_range(61, 63)),
             $urandom, $urandom);
      end else if (pick < 97) begin
        send(KIND_PUSH_DATA, $urandom, $urandom, $urandom);
      end else begin
        // Broken push: a new begin lands while the previous one is still open.
        send(KIND_PUSH_BEGIN, len, $urandom, $urandom);
        repeat ($urandom_range(0, len - 1)) send(KIND_PUSH_DATA, $urandom, $urandom, $urandom);
        send(KIND_PUSH_BEGIN, $urandom_range(1, 60), $urandom, $urandom);
      end
    end
    drain();
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    request    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    cycles     = 0;
    sent       = 0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty ring, unknown kinds, stray data, bad lengths.
    send(KIND_POP, 6'd0, 8'd0, 6'd60);
    send(KIND_PEEK, 6'd0, 8'd0, 6'd0);
    send(KIND_DISCARD, 6'd0, 8'd0, 6'd0);
    send(KIND_PUSH_DATA, 6'd0, 8'hFF, 6'd0);
    send(3'd5, 6'h3F, 8'hFF, 6'h3F);
    send(3'd6, 6'd0, 8'd0, 6'd0);
    send(3'd7, 6'd0, 8'd0, 6'd0);
    send(KIND_PUSH_BEGIN, 6'd0, 8'd0, 6'd0);
    send(KIND_PUSH_BEGIN, 6'd61, 8'd0, 6'd0);
    send(KIND_PUSH_BEGIN, 6'h3F, 8'd0, 6'd0);
    // Smallest message, then a push interrupted by a second begin.
    send(KIND_PUSH_BEGIN, 6'd1, 8'd0, 6'd0);
    send(KIND_PUSH_DATA, 6'd0, 8'h00, 6'd0);
    send(KIND_PUSH_BEGIN, 6'd2, 8'd0, 6'd0);
    send(KIND_PUSH_BEGIN, 6'd60, 8'd0, 6'd0);
    send(KIND_PUSH_DATA, 6'd0, 8'hFF, 6'd0);
    send(KIND_PUSH_DATA, 6'd0, 8'hA5, 6'd0);
    // Too small an output limit, then peek, pop and discard.
    send(KIND_POP, 6'd0, 8'd0, 6'd0);
    send(KIND_PEEK, 6'd0, 8'd0, 6'd0);
    send(KIND_POP, 6'd0, 8'd0, 6'd1);
    send(KIND_POP, 6'd0, 8'd0, 6'd1);
    send(KIND_DISCARD, 6'd0, 8'd0, 6'd0);
    send(KIND_POP, 6'd0, 8'd0, 6'd60);
    drain();

    random_phase(60);
    // Sweep capacity and reserve through their extremes; small rings force wraps.
    write_reg(CFG_CAPACITY, 13'd64);
    write_reg(CFG_RESERVE, 13'd0);
    random_phase(80);
    write_reg(CFG_CAPACITY, 13'd100);
    write_reg(CFG_RESERVE, 13'h1FFF);
    random_phase(40);
    write_reg(CFG_CAPACITY, 13'h1FFF);
    write_reg(CFG_RESERVE, 13'd20);
    random_phase(70);
    write_reg(CFG_CAPACITY, 13'd0);
    write_reg(CFG_RESERVE, 13'd8);
    random_phase(80);
    write_reg(CFG_CAPACITY, 13'd150);
    write_reg(CFG_RESERVE, 13'd3);
    random_phase(80);
    write_reg(CFG_CAPACITY, 13'd4096);
    write_reg(CFG_RESERVE, 13'd255);
    random_phase(60);

    // Give any straggling result time to show up.
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
